/* hdl/lru_key_cache_controller_macros.svh */
// ----------------------------------------------------------------------------
// LRU key cache controller assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_CACHE_CONTROLLER_MACROS_SVH
`define LRU_KEY_CACHE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define LKCC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkcc assertion failed");
`define LKCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkcc assertion failed");
`define LKCC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("lkcc assertion failed");
`else
`define LKCC_ASSERT_IMPLY(label, ante, cons)
`define LKCC_ASSERT_NEXT(label, ante, cons)
`define LKCC_ASSERT_ALWAYS(label, cond)
`endif
`endif

/* hdl/lkcc_pkg.sv */
// ----------------------------------------------------------------------------
// lkcc_pkg
// Shared types and constants of the LRU key cache controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lkcc_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int FIELD_KEY_W   = 32;
    localparam int CFG_W         = 5;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_PROBE  = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_RSVD   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [FIELD_KEY_W-1:0] key;
        logic                   owner_supplies;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic                   inserted;
        logic                   evicted;
        logic [FIELD_KEY_W-1:0] evicted_key;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic commit;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hdl/lkcc_datapath.sv */
// ----------------------------------------------------------------------------
// lkcc_datapath
// Key/valid/rank store, parallel tag compare, recency update, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_cache_controller_macros.svh"

module lkcc_datapath
    import lkcc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire t_in_item         i_in_data,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output t_out_item             o_out_data
);

    localparam int RANK_W = $clog2(CAPACITY);
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int LIM_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    // architectural state
    logic [KEY_BITS-1:0] r_keys [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [RANK_W-1:0]   r_rank [CAPACITY];
    logic [OCC_W-1:0]    r_occ;
    logic [CFG_W-1:0]    r_active;

    // item and lookup results
    t_in_item            r_in;
    logic [CAPACITY-1:0] r_hit_vec;
    logic                r_hit;
    logic [RANK_W-1:0]   r_hit_rank;
    logic [CAPACITY-1:0] r_evict_vec;
    logic                r_need_evict;
    logic [KEY_BITS-1:0] r_evk;
    logic [CAPACITY-1:0] r_free_vec;
    t_out_item           r_out;

    logic [KEY_BITS-1:0] in_key;
    logic [LIM_W-1:0]    cfg_ext;
    logic [LIM_W-1:0]    limit;
    logic                need_evict;
    logic [RANK_W-1:0]   last_rank;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] evict_vec;
    logic [RANK_W-1:0]   hit_rank;
    logic [KEY_BITS-1:0] evk;
    logic [CAPACITY-1:0] vacant;
    logic [CAPACITY-1:0] free_vec;

    logic                is_access;
    logic                is_probe;
    logic                do_flush;
    logic                do_hit;
    logic                do_ins;
    logic [CAPACITY-1:0] n_valid;
    logic [RANK_W-1:0]   n_rank [CAPACITY];
    logic [OCC_W-1:0]    n_occ;
    t_out_item           n_out;

    assign in_key = KEY_BITS'(r_in.key);

    // size register: zero acts as one, clamp to capacity
    assign cfg_ext    = LIM_W'(r_active);
    always_comb begin
        limit = cfg_ext;
        if (cfg_ext == '0) begin
            limit = LIM_W'(1);
        end else if (cfg_ext > LIM_W'(CAPACITY)) begin
            limit = LIM_W'(CAPACITY);
        end
    end
    assign need_evict = (LIM_W'(r_occ) >= limit);
    assign last_rank  = RANK_W'(r_occ - OCC_W'(1));

    // lookup: parallel compare against every entry
    always_comb begin
        hit_vec   = '0;
        evict_vec = '0;
        hit_rank  = '0;
        evk       = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_vec[i]   = r_valid[i] && (r_keys[i] == in_key);
            evict_vec[i] = r_valid[i] && (r_rank[i] == last_rank);
            hit_rank     = hit_rank | (hit_vec[i] ? r_rank[i] : '0);
            evk          = evk | (evict_vec[i] ? r_keys[i] : '0);
        end
    end

    // lowest free slot once the victim is gone
    assign vacant   = ~r_valid | (need_evict ? evict_vec : '0);
    assign free_vec = vacant & (~vacant + CAPACITY'(1));

    // update
    assign is_access = (r_in.opcode == OP_ACCESS);
    assign is_probe  = (r_in.opcode == OP_PROBE);
    assign do_flush  = (r_in.opcode == OP_FLUSH);
    assign do_hit    = is_access && r_hit;
    assign do_ins    = is_access && !r_hit && r_in.owner_supplies;

    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
            if (do_flush) begin
                n_valid[i] = 1'b0;
                n_rank[i]  = '0;
            end else if (do_hit) begin
                if (r_hit_vec[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (do_ins) begin
                if (r_free_vec[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_evict_vec[i]) begin
                    n_valid[i] = 1'b0;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_occ = r_occ;
        if (do_flush) begin
            n_occ = '0;
        end else if (do_ins && !r_need_evict) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    always_comb begin
        n_out.hit         = (is_access || is_probe) && r_hit;
        n_out.inserted    = do_ins;
        n_out.evicted     = do_ins && r_need_evict;
        n_out.evicted_key = (do_ins && r_need_evict) ? FIELD_KEY_W'(r_evk) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_occ    <= '0;
            r_active <= ACTIVE_RESET;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_rank  <= n_rank;
                r_occ   <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.lookup) begin
            r_hit_vec    <= hit_vec;
            r_hit        <= |hit_vec;
            r_hit_rank   <= hit_rank;
            r_evict_vec  <= need_evict ? evict_vec : '0;
            r_need_evict <= need_evict;
            r_evk        <= evk;
            r_free_vec   <= free_vec;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (i_cmd.commit && do_ins && r_free_vec[i]) begin
                r_keys[i] <= in_key;
            end
        end
    end

    assign o_out_data = r_out;

    `LKCC_ASSERT_ALWAYS(a_occ_matches_valid, $countones(r_valid) == r_occ)
    `LKCC_ASSERT_IMPLY(a_single_hit, i_cmd.commit, $onehot0(r_hit_vec))
    `LKCC_ASSERT_IMPLY(a_insert_has_slot, i_cmd.commit && do_ins, $onehot(r_free_vec))

endmodule

`default_nettype wire

/* hdl/lkcc_ctrl.sv */
// ----------------------------------------------------------------------------
// lkcc_ctrl
// Sequencer: accept, lookup, update; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_key_cache_controller_macros.svh"

module lkcc_ctrl
    import lkcc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LOOKUP = 3'b010,
        S_UPDATE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   commit;
    logic   accept;

    // update may land only when the result register is free or draining
    assign commit     = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || commit;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (commit) begin
                    n_state = accept ? S_LOOKUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.load_in = accept;
    assign o_cmd.lookup  = (r_state == S_LOOKUP);
    assign o_cmd.commit  = commit;
    assign o_out_valid   = r_out_valid;

    `LKCC_ASSERT_NEXT(a_accept_to_lookup, i_in_valid && o_in_ready, r_state == S_LOOKUP)
    `LKCC_ASSERT_NEXT(a_lookup_to_update, r_state == S_LOOKUP, r_state == S_UPDATE)
    `LKCC_ASSERT_NEXT(a_commit_shows_beat, commit, o_out_valid)

endmodule

`default_nettype wire

/* hdl/lru_key_cache_controller.sv */
// ----------------------------------------------------------------------------
// lru_key_cache_controller
// Fully associative LRU key store: access, probe and flush with eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid/o_in_ready carries one item (opcode, key,
//   owner_supplies) per beat; output channel o_out_valid/i_out_ready returns
//   exactly one result beat (hit, inserted, evicted, evicted_key) per item,
//   in order. The size register is written on i_cfg_valid/o_cfg_ready, which
//   is always ready; write it only while no item is in flight.
//   The input item is registered, then the parallel tag compare over all
//   entries is registered, then the recency update commits with the
//   result register. A new item is taken only while idle or as the
//   previous update commits, as each item sees the state the last one left.
//   Reset (synchronous, active low) empties the store and sets the size to
//   16; no clearing pass is needed.
//   When the receiver stalls, the finished result is held in the output
//   register; one more item is accepted and looked up, and its update waits
//   until the held beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_cache_controller
    import lkcc_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_item         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_item             o_out_data,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    lkcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    lkcc_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

/* tb/lru_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU result checker
// Watches the item, result and size-write channels of the LRU key cache
// controller, keeps its own copy of the key store and recency order, and
// compares each result beat with the predicted one, oldest first.
// ----------------------------------------------------------------------------

module lru_result_checker
    import lkcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_in_item             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_out_item            i_out_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    localparam int SLOTS = CAPACITY_DEF;

    logic [FIELD_KEY_W-1:0] slot_key   [SLOTS];
    logic                   slot_valid [SLOTS];
    logic [3:0]             slot_rank  [SLOTS];
    logic [4:0]             fill_count;
    logic [CFG_W-1:0]       size_reg;

    t_out_item expected_results [$];
    int        pending;
    int        mismatch_total;

    assign o_pending    = pending;
    assign o_fail_count = mismatch_total;

    // Applies one item to the shadow store and returns the result it yields.
    function automatic t_out_item lru_next_result(input t_in_item item);
        t_out_item  res;
        int         found;
        int         lim;
        logic [3:0] hit_rank;
        logic [3:0] oldest;
        logic       dropped;
        logic       placed;
        res      = '0;
        found    = -1;
        dropped  = 1'b0;
        placed   = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_key[i] == item.key)
                found = i;
        lim = (size_reg == 0) ? 1 : ((size_reg > SLOTS) ? SLOTS : int'(size_reg));

        case (t_opcode'(item.opcode))
            OP_ACCESS: begin
                if (found >= 0) begin
                    res.hit  = 1'b1;
                    hit_rank = slot_rank[found];
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && slot_rank[i] < hit_rank)
                            slot_rank[i] = slot_rank[i] + 4'd1;
                    slot_rank[found] = '0;
                end else if (item.owner_supplies) begin
                    res.inserted = 1'b1;
                    // only the single least recent entry goes, even if size shrank
                    if (int'(fill_count) + 1 > lim && fill_count > 0) begin
                        oldest = 4'(fill_count - 5'd1);
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!dropped && slot_valid[i] && slot_rank[i] == oldest) begin
                                dropped         = 1'b1;
                                res.evicted     = 1'b1;
                                res.evicted_key = slot_key[i];
                                slot_valid[i]   = 1'b0;
                                slot_rank[i]    = '0;
                                fill_count      = fill_count - 5'd1;
                            end
                        end
                    end
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_valid[i])
                            slot_rank[i] = slot_rank[i] + 4'd1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!placed && !slot_valid[i]) begin
                            placed        = 1'b1;
                            slot_valid[i] = 1'b1;
                            slot_key[i]   = item.key;
                            slot_rank[i]  = '0;
                            fill_count    = fill_count + 5'd1;
                        end
                    end
                end
            end
            OP_PROBE: res.hit = (found >= 0);
            OP_FLUSH: begin
                for (int i = 0; i < SLOTS; i++) begin
                    slot_valid[i] = 1'b0;
                    slot_rank[i]  = '0;
                end
                fill_count = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = '0;
            end
            fill_count     = '0;
            size_reg       = ACTIVE_RESET;
            mismatch_total = 0;
            expected_results.delete();
            pending <= 0;
        end else begin
            // compare before predicting: a beat this edge belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no item outstanding");
                    mismatch_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_out_data.hit);
                        mismatch_total++;
                    end
                    if (i_out_data.inserted !== want.inserted) begin
                        $error("inserted: expected %0d, got %0d",
                               want.inserted, i_out_data.inserted);
                        mismatch_total++;
                    end
                    if (i_out_data.evicted !== want.evicted) begin
                        $error("evicted: expected %0d, got %0d",
                               want.evicted, i_out_data.evicted);
                        mismatch_total++;
                    end
                    if (i_out_data.evicted_key !== want.evicted_key) begin
                        $error("evicted_key: expected %08h, got %08h",
                               want.evicted_key, i_out_data.evicted_key);
                        mismatch_total++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                size_reg = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expected_results.push_back(lru_next_result(i_in_data));
            pending <= expected_results.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key cache controller testbench
// Drives access, probe, flush and reserved items through the controller
// under a range of cache sizes, with random output back-pressure and input
// idle gaps. A directed opening covers the corner cases; random phases follow,
// each with its own size, key pool and idle rate. The checker does the scoring.
// ----------------------------------------------------------------------------

module testbench;
    import lkcc_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 150;
    localparam int POOL_MAX    = 24;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             in_valid    = 1'b0;
    t_in_item         in_data     = '0;
    logic             out_ready   = 1'b0;
    logic             cfg_valid   = 1'b0;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             in_ready;
    logic             out_valid;
    t_out_item        out_data;
    logic             cfg_ready;
    int               pending;
    int               fail_count;

    int                     gap_pct = 0;
    int                     stall_left = 0;
    logic [FIELD_KEY_W-1:0] key_pool [POOL_MAX];
    int                     pool_n;

    lru_key_cache_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    lru_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(1, 12) - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic t_in_item make_item(input t_opcode op,
                                           input logic [FIELD_KEY_W-1:0] k,
                                           input logic own);
        t_in_item it;
        it.opcode         = op;
        it.key            = k;
        it.owner_supplies = own;
        return it;
    endfunction

    // valid stays up across back-to-back beats
    task automatic send_item(input t_in_item it);
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] sz);
        cfg_valid <= 1'b1;
        cfg_data  <= sz;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item();
        t_in_item         it;
        int               pick;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 72)
            it.opcode = OP_ACCESS;
        else if (pick < 92)
            it.opcode = OP_PROBE;
        else if (pick < 96)
            it.opcode = OP_FLUSH;
        else
            it.opcode = OP_RSVD;
        if ($urandom_range(0, 99) < 8)
            it.key = $urandom();
        else
            it.key = key_pool[$urandom_range(0, pool_n - 1)];
        it.owner_supplies = ($urandom_range(0, 9) != 0);
        send_item(it);
    endtask

    initial begin
        logic [CFG_W-1:0] sz;
        int               eff;
        int               phase_size [PHASES];
        phase_size = '{1, 0, 16, 31, 17, 2, 8, 0, 5, 16};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, no-owner miss, both key extremes, reserved op, flush
        send_item(make_item(OP_PROBE,  32'h0000_0000, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_ACCESS, 32'h0000_0000, 1'b1));
        send_item(make_item(OP_ACCESS, 32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_PROBE,  32'hFFFF_FFFF, 1'b0));
        send_item(make_item(OP_ACCESS, 32'h0000_0000, 1'b0));
        send_item(make_item(OP_RSVD,   32'h0000_0000, 1'b1));
        send_item(make_item(OP_FLUSH,  32'hFFFF_FFFF, 1'b1));
        send_item(make_item(OP_PROBE,  32'h0000_0000, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_000A, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_000B, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_000C, 1'b1));
        // size zero acts as one, and lies below occupancy: one eviction per insert
        drain_results();
        write_size('0);
        send_item(make_item(OP_ACCESS, 32'h0000_000D, 1'b1));
        send_item(make_item(OP_PROBE,  32'h0000_000B, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_000B, 1'b1));
        send_item(make_item(OP_ACCESS, 32'h0000_000E, 1'b1));
        send_item(make_item(OP_PROBE,  32'h0000_000C, 1'b0));
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            sz = (p == 7) ? CFG_W'($urandom_range(0, 31)) : CFG_W'(phase_size[p]);
            write_size(sz);
            eff    = (sz == 0) ? 1 : ((sz > 16) ? 16 : int'(sz));
            pool_n = eff + $urandom_range(1, 8);
            if (pool_n > POOL_MAX)
                pool_n = POOL_MAX;
            for (int i = 0; i < POOL_MAX; i++)
                key_pool[i] = $urandom();
            if ($urandom_range(0, 1) == 0)
                key_pool[$urandom_range(0, pool_n - 1)] = '0;
            if ($urandom_range(0, 1) == 0)
                key_pool[$urandom_range(0, pool_n - 1)] = '1;
            if (p == PHASES - 1)
                gap_pct = 0;
            else
                gap_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
